>>> sv/ascf_pkg.sv
package ascf_pkg;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_REPLAY,
    ST_TAIL
  } fsm_state_t;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_PARAMS,
    PH_FULL
  } parse_phase_t;

  localparam int REPLAY_DEPTH_DEF = 32;
  localparam int MAX_CODES_DEF    = 4;

  localparam logic [15:0] CH_ESC      = 16'h001b;
  localparam logic [15:0] CH_LBRACKET = 16'h005b;
  localparam logic [15:0] CH_SEMI     = 16'h003b;
  localparam logic [15:0] CH_FINAL_M  = 16'h006d;
  localparam logic [15:0] CH_ZERO     = 16'h0030;
  localparam logic [15:0] CH_NINE     = 16'h0039;

  localparam logic [9:0]  CODE_SAT = 10'd1023;

  localparam logic [3:0]  FG_DEF = 4'd7;
  localparam logic [3:0]  BG_DEF = 4'd0;
  localparam logic [7:0]  ATTR_DEF = {BG_DEF, FG_DEF};

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_ATTR = 1'b1;

  // SGR code to attribute update; attr is {bg, fg}
  function automatic logic [7:0] apply_code(logic [9:0] code, logic [7:0] attr);
    logic [7:0] res;
    res = attr;
    case (code)
      10'd0:   res = ATTR_DEF;
      10'd31:  res = {attr[7:4], 4'd4};
      10'd32:  res = {attr[7:4], 4'd2};
      10'd33:  res = {attr[7:4], 4'd14};
      10'd36:  res = {attr[7:4], 4'd3};
      10'd37:  res = {attr[7:4], 4'd7};
      10'd41:  res = {4'd4, attr[3:0]};
      10'd90:  res = {attr[7:4], 4'd8};
      10'd97:  res = {attr[7:4], 4'd15};
      default: res = attr;
    endcase
    return res;
  endfunction

endpackage

>>> sv/ansi_sgr_color_filter.sv
// ANSI SGR color filter: takes one 16-bit character per request and passes plain
// characters through as text results. ESC '[' opens a color sequence of up to
// MAX_CODES decimal codes split by ';'; the closing 'm' yields one attribute result
// (fg in the low nibble, bg in the high nibble). The '[' and parameter characters
// are kept in a REPLAY_DEPTH-entry buffer memory; a malformed sequence or an
// end-of-string mark plays them back as text, followed by the failing character
// (none if it is ESC, which opens a new sequence) or by attribute 7/0. Throughput
// is one request per cycle while results are taken. A request that triggers a
// playback holds the input while the buffered characters and any trailing result
// are sent, since the buffer has a single read port that yields one character per
// cycle. There is a single result register, so an untaken result holds the input.
module ansi_sgr_color_filter #(
  parameter int REPLAY_DEPTH = ascf_pkg::REPLAY_DEPTH_DEF,
  parameter int MAX_CODES    = ascf_pkg::MAX_CODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] ch,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [15:0] text_char,
  output logic [7:0]  attribute,
  output logic        last_of_run
);
  import ascf_pkg::*;

  localparam int IDX_W = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;
  localparam int CNT_W = $clog2(REPLAY_DEPTH + 1);
  localparam int CC_W  = $clog2(MAX_CODES + 1);

  fsm_state_t   state, state_next;
  parse_phase_t phase, phase_next;

  logic [9:0]       code_value, code_value_next;
  logic             digit_seen, digit_seen_next;
  logic [CC_W-1:0]  code_count, code_count_next;
  logic [7:0]       pend_attr, pend_attr_next;
  logic [CNT_W-1:0] replay_count, replay_count_next;
  logic [IDX_W-1:0] rd_idx;
  logic             tail_has, tail_has_next;
  logic             tail_kind, tail_kind_next;
  logic [15:0]      tail_char;

  logic [15:0] mem [REPLAY_DEPTH];
  logic [15:0] rdata;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  logic out_free, accept, rd_last;
  logic emit_now, e_kind;
  logic [15:0] e_char;
  logic [7:0]  e_attr;
  logic go_replay;

  logic        out_load, o_kind, o_last;
  logic [15:0] o_char;
  logic [7:0]  o_attr;

  logic        is_digit;
  logic [13:0] code_sum;
  logic [7:0]  commit_attr;
  logic [CC_W-1:0] commit_count;

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign rd_last  = (CNT_W'(rd_idx) + CNT_W'(1)) == replay_count;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign code_sum = {1'b0, code_value, 3'b000} + {3'b000, code_value, 1'b0}
                  + {10'd0, ch[3:0]};
  assign commit_attr  = digit_seen ? apply_code(code_value, pend_attr) : pend_attr;
  assign commit_count = digit_seen ? code_count + CC_W'(1) : code_count;

  // request decode
  always_comb begin
    phase_next        = phase;
    code_value_next   = code_value;
    digit_seen_next   = digit_seen;
    code_count_next   = code_count;
    pend_attr_next    = pend_attr;
    replay_count_next = replay_count;
    wr_en             = 1'b0;
    emit_now          = 1'b0;
    e_kind            = KIND_TEXT;
    e_char            = ch;
    e_attr            = 8'd0;
    go_replay         = 1'b0;
    tail_has_next     = 1'b0;
    tail_kind_next    = KIND_TEXT;
    if (end_of_string) begin
      phase_next      = PH_TEXT;
      code_value_next = 10'd0;
      digit_seen_next = 1'b0;
      code_count_next = '0;
      if (replay_count == '0) begin
        emit_now = 1'b1;
        e_kind   = KIND_ATTR;
        e_char   = 16'd0;
        e_attr   = ATTR_DEF;
      end else begin
        go_replay      = 1'b1;
        tail_has_next  = 1'b1;
        tail_kind_next = KIND_ATTR;
      end
    end else begin
      case (phase)
        PH_TEXT, PH_ESC: begin
          if (phase == PH_ESC && ch == CH_LBRACKET) begin
            phase_next        = PH_PARAMS;
            code_value_next   = 10'd0;
            digit_seen_next   = 1'b0;
            code_count_next   = '0;
            pend_attr_next    = ATTR_DEF;
            wr_en             = 1'b1;
            replay_count_next = CNT_W'(1);
          end else if (ch == CH_ESC) begin
            phase_next = PH_ESC;
          end else begin
            phase_next = PH_TEXT;
            emit_now   = 1'b1;
          end
        end
        PH_PARAMS, PH_FULL: begin
          if (ch == CH_FINAL_M) begin
            phase_next        = PH_TEXT;
            code_value_next   = 10'd0;
            digit_seen_next   = 1'b0;
            code_count_next   = '0;
            replay_count_next = '0;
            pend_attr_next    = (phase == PH_PARAMS) ? commit_attr : pend_attr;
            emit_now          = 1'b1;
            e_kind            = KIND_ATTR;
            e_char            = 16'd0;
            e_attr            = pend_attr_next;
          end else if (phase == PH_PARAMS && (is_digit || ch == CH_SEMI)
                       && replay_count < CNT_W'(REPLAY_DEPTH)) begin
            wr_en             = 1'b1;
            replay_count_next = replay_count + CNT_W'(1);
            if (ch == CH_SEMI) begin
              pend_attr_next  = commit_attr;
              code_count_next = commit_count;
              code_value_next = 10'd0;
              digit_seen_next = 1'b0;
              if (commit_count >= CC_W'(MAX_CODES)) begin
                phase_next = PH_FULL;
              end
            end else begin
              code_value_next = (code_sum > {4'd0, CODE_SAT}) ? CODE_SAT : code_sum[9:0];
              digit_seen_next = 1'b1;
            end
          end else begin
            // malformed: play back the buffer, then handle ch as plain input
            go_replay       = 1'b1;
            code_value_next = 10'd0;
            digit_seen_next = 1'b0;
            code_count_next = '0;
            if (ch == CH_ESC) begin
              phase_next = PH_ESC;
            end else begin
              phase_next     = PH_TEXT;
              tail_has_next  = 1'b1;
              tail_kind_next = KIND_TEXT;
            end
          end
        end
        default: begin
          phase_next = PH_TEXT;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (accept && go_replay) begin
          state_next = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (out_free && rd_last) begin
          state_next = tail_has ? ST_TAIL : ST_RUN;
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = '0;
    out_load = 1'b0;
    o_kind   = KIND_TEXT;
    o_char   = 16'd0;
    o_attr   = 8'd0;
    o_last   = 1'b1;
    case (state)
      ST_RUN: begin
        // entry 0 is read every cycle so a playback can start right away
        in_ready = out_free;
        out_load = accept && emit_now;
        o_kind   = e_kind;
        o_char   = e_char;
        o_attr   = e_attr;
      end
      ST_REPLAY: begin
        out_load = out_free;
        o_char   = rdata;
        o_last   = rd_last && !tail_has;
        if (out_free) begin
          rd_addr = rd_last ? '0 : rd_idx + IDX_W'(1);
        end else begin
          rd_addr = rd_idx;
        end
      end
      ST_TAIL: begin
        out_load = out_free;
        o_kind   = tail_kind;
        o_char   = (tail_kind == KIND_TEXT) ? tail_char : 16'd0;
        o_attr   = (tail_kind == KIND_ATTR) ? ATTR_DEF : 8'd0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[replay_count[IDX_W-1:0]] <= ch;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      phase        <= PH_TEXT;
      code_value   <= 10'd0;
      digit_seen   <= 1'b0;
      code_count   <= '0;
      pend_attr    <= ATTR_DEF;
      replay_count <= '0;
      rd_idx       <= '0;
      tail_has     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        phase        <= phase_next;
        code_value   <= code_value_next;
        digit_seen   <= digit_seen_next;
        code_count   <= code_count_next;
        pend_attr    <= pend_attr_next;
        replay_count <= replay_count_next;
        if (go_replay) begin
          tail_has <= tail_has_next;
        end
      end
      if (state == ST_REPLAY && out_free) begin
        rd_idx <= rd_last ? '0 : rd_idx + IDX_W'(1);
        if (rd_last) begin
          replay_count <= '0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && go_replay) begin
      tail_kind <= tail_kind_next;
      tail_char <= ch;
    end
    if (out_load) begin
      kind        <= o_kind;
      text_char   <= o_char;
      attribute   <= o_attr;
      last_of_run <= o_last;
    end
  end

endmodule
